// ===== rtl/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared constants and register codes for the camera perspective projection.
// ----------------------------------------------------------------------------
package cpp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TRIG_WIDTH      = 16;
    localparam int TAN_WIDTH       = 24;
    localparam int ROT_FRAC        = 14;
    localparam int SCREEN_SCALE    = 100;
    localparam int SCALE_BITS      = 7;
    localparam int PROJ_SHIFT      = 32;
    localparam int CFG_INDEX_WIDTH = 4;

    localparam int CAM_POS_Z_RESET = -327680;
    localparam int TRIG_ONE        = 16384;
    localparam int TAN_RESET       = 65536;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CAM_POS_X    = CFG_INDEX_WIDTH'(0),
        REG_CAM_POS_Y    = CFG_INDEX_WIDTH'(1),
        REG_CAM_POS_Z    = CFG_INDEX_WIDTH'(2),
        REG_COS_YAW      = CFG_INDEX_WIDTH'(3),
        REG_SIN_YAW      = CFG_INDEX_WIDTH'(4),
        REG_COS_PITCH    = CFG_INDEX_WIDTH'(5),
        REG_SIN_PITCH    = CFG_INDEX_WIDTH'(6),
        REG_TAN_HALF_FOV = CFG_INDEX_WIDTH'(7)
    } cfg_reg_t;

endpackage

// ===== rtl/cpp_div.sv =====
// ----------------------------------------------------------------------------
// cpp_div
// Pipelined restoring divider with signed saturation, one quotient bit per
// stage. Stage zero detects a quotient at or above the signed range.
// ----------------------------------------------------------------------------
module cpp_div #(
    parameter int W = cpp_pkg::COORD_WIDTH_DEF
) (
    input  logic                                             clk,
    input  logic                                             en,
    input  logic [W+cpp_pkg::SCALE_BITS+cpp_pkg::PROJ_SHIFT-1:0] num,
    input  logic [cpp_pkg::TAN_WIDTH+W-2:0]                  den,
    input  logic                                             neg,
    output logic [W-1:0]                                     quot
);
    import cpp_pkg::*;

    localparam int DENW = TAN_WIDTH + W - 1;
    localparam int EW   = DENW + W;
    localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

    logic [EW-1:0]   rem_reg [W-1];
    logic [DENW-1:0] den_reg [W-1];
    logic [W-1:0]    q_reg   [W];
    logic            ovf_reg [W];
    logic            neg_reg [W];

    logic [EW-1:0] num_ext;
    logic [EW-1:0] den_top;
    logic          ovf_next;

    always_comb
    begin
        num_ext  = EW'(num);
        den_top  = EW'(den) << (W - 1);
        ovf_next = (|num) && (num_ext >= den_top);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_ext;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 1; k < W; k++)
    begin : g_stage
        localparam int BIT = W - 1 - k;

        logic [EW:0]   diff;
        logic          take;
        logic [W-1:0]  q_next;

        always_comb
        begin
            diff        = {1'b0, rem_reg[k-1]} - {1'b0, EW'(den_reg[k-1]) << BIT};
            take        = ~diff[EW] & (|den_reg[k-1]);
            q_next      = q_reg[k-1];
            q_next[BIT] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]   <= q_next;
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end

        if (k < W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? diff[EW-1:0] : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        if (ovf_reg[W-1])
            quot = neg_reg[W-1] ? QMIN : QMAX;
        else
            quot = neg_reg[W-1] ? (~q_reg[W-1] + 1'b1) : q_reg[W-1];
    end

endmodule

// ===== rtl/camera_perspective_projection.sv =====
// ----------------------------------------------------------------------------
// camera_perspective_projection
// Projects world-space vertices through a yaw/pitch camera to screen space.
//
// Input beats on s_axis carry one vertex; output beats on m_axis carry the
// screen coordinates, the camera-space depth and a behind-camera flag in
// tuser. Camera position, trig values and tan(fov/2) are written on the cfg
// channel, which is always ready; write it only while no vertex is in flight.
// One vertex per cycle is accepted while s_axis_tready is high. Most of
// the pipeline is the restoring divider (two run in parallel), one
// quotient bit per pipeline stage.
// Stages: translate, yaw multiply, yaw sum, pitch multiply, pitch sum,
// numerator/denominator, COORD_WIDTH divider stages, output register.
// Reset loads the default camera and empties the pipeline.
// When the receiver stalls, a skid register takes one more result; then the
// pipeline freezes and s_axis_tready drops until the skid drains.
// ----------------------------------------------------------------------------
module camera_perspective_projection #(
    parameter int COORD_WIDTH = cpp_pkg::COORD_WIDTH_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // vertex_x, vertex_y, vertex_z, zero pad
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // screen_x, screen_y, depth, zero pad
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    // behind_camera
    output logic                                       m_axis_tuser,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [cpp_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [COORD_WIDTH-1:0]                     cfg_data
);
    import cpp_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int W1     = W + 1;
    localparam int TW1    = TRIG_WIDTH + 1;
    localparam int PW     = W + TRIG_WIDTH + 1;
    localparam int SW     = PW + 1;
    localparam int MW     = W + SCALE_BITS;
    localparam int NUMW   = MW + PROJ_SHIFT;
    localparam int DENW   = TAN_WIDTH + W - 1;
    localparam int DATA_W = ((3 * W + 7) / 8) * 8;
    localparam int RES_W  = 3 * W + 1;
    localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] d;
        d = W1'(a) - W1'(b);
        if (d[W] != d[W-1])
            return d[W] ? COORD_MIN : COORD_MAX;
        return d[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_rot(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] sh;
        sh = s >>> ROT_FRAC;
        if (sh > SW'(COORD_MAX))
            return COORD_MAX;
        if (sh < SW'(COORD_MIN))
            return COORD_MIN;
        return sh[W-1:0];
    endfunction

    function automatic logic signed [TRIG_WIDTH:0] trig_ext(
        input logic signed [TRIG_WIDTH-1:0] t, input logic negate);
        logic signed [TRIG_WIDTH:0] e;
        e = TW1'(t);
        return negate ? -e : e;
    endfunction

    function automatic logic [NUMW-1:0] scaled_mag(input logic signed [W-1:0] c);
        logic [W-1:0]  mag;
        logic [MW-1:0] prod;
        mag  = c[W-1] ? (~c + 1'b1) : c;
        prod = MW'(mag) * MW'(SCREEN_SCALE);
        return {prod, {PROJ_SHIFT{1'b0}}};
    endfunction

    // configuration registers
    logic signed [W-1:0]          cam_pos_x_reg;
    logic signed [W-1:0]          cam_pos_y_reg;
    logic signed [W-1:0]          cam_pos_z_reg;
    logic signed [TRIG_WIDTH-1:0] cos_yaw_reg;
    logic signed [TRIG_WIDTH-1:0] sin_yaw_reg;
    logic signed [TRIG_WIDTH-1:0] cos_pitch_reg;
    logic signed [TRIG_WIDTH-1:0] sin_pitch_reg;
    logic [TAN_WIDTH-1:0]         tan_half_fov_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_pos_x_reg    <= '0;
            cam_pos_y_reg    <= '0;
            cam_pos_z_reg    <= W'(CAM_POS_Z_RESET);
            cos_yaw_reg      <= TRIG_WIDTH'(TRIG_ONE);
            sin_yaw_reg      <= '0;
            cos_pitch_reg    <= TRIG_WIDTH'(TRIG_ONE);
            sin_pitch_reg    <= '0;
            tan_half_fov_reg <= TAN_WIDTH'(TAN_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CAM_POS_X:    cam_pos_x_reg    <= cfg_data;
                REG_CAM_POS_Y:    cam_pos_y_reg    <= cfg_data;
                REG_CAM_POS_Z:    cam_pos_z_reg    <= cfg_data;
                REG_COS_YAW:      cos_yaw_reg      <= cfg_data[TRIG_WIDTH-1:0];
                REG_SIN_YAW:      sin_yaw_reg      <= cfg_data[TRIG_WIDTH-1:0];
                REG_COS_PITCH:    cos_pitch_reg    <= cfg_data[TRIG_WIDTH-1:0];
                REG_SIN_PITCH:    sin_pitch_reg    <= cfg_data[TRIG_WIDTH-1:0];
                REG_TAN_HALF_FOV: tan_half_fov_reg <= cfg_data[TAN_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    // pipeline control
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic dly_valid_reg [W];

    assign en            = ~skid_valid_reg;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            for (int i = 0; i < W; i++)
                dly_valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg     <= s_axis_tvalid;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            s5_valid_reg     <= s4_valid_reg;
            s6_valid_reg     <= s5_valid_reg;
            dly_valid_reg[0] <= s6_valid_reg;
            for (int i = 1; i < W; i++)
                dly_valid_reg[i] <= dly_valid_reg[i-1];
        end
    end

    // stage 1: translate
    logic signed [W-1:0] vx, vy, vz;
    logic signed [W-1:0] tx_reg, ty_reg, tz_reg;

    assign vx = s_axis_tdata[W-1:0];
    assign vy = s_axis_tdata[2*W-1:W];
    assign vz = s_axis_tdata[3*W-1:2*W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg <= sat_sub(vx, cam_pos_x_reg);
            ty_reg <= sat_sub(vy, cam_pos_y_reg);
            tz_reg <= sat_sub(vz, cam_pos_z_reg);
        end
    end

    // stage 2: yaw products
    logic signed [TRIG_WIDTH:0] cy_e, sy_e, nsy_e, cp_e, sp_e, nsp_e;
    logic signed [PW-1:0] yxc_next, yzs_next, yxs_next, yzc_next;
    logic signed [PW-1:0] yxc_reg, yzs_reg, yxs_reg, yzc_reg;
    logic signed [W-1:0]  ty2_reg;

    always_comb
    begin
        cy_e     = trig_ext(cos_yaw_reg, 1'b0);
        sy_e     = trig_ext(sin_yaw_reg, 1'b0);
        nsy_e    = trig_ext(sin_yaw_reg, 1'b1);
        cp_e     = trig_ext(cos_pitch_reg, 1'b0);
        sp_e     = trig_ext(sin_pitch_reg, 1'b0);
        nsp_e    = trig_ext(sin_pitch_reg, 1'b1);
        yxc_next = PW'(tx_reg) * PW'(cy_e);
        yzs_next = PW'(tz_reg) * PW'(sy_e);
        yxs_next = PW'(tx_reg) * PW'(nsy_e);
        yzc_next = PW'(tz_reg) * PW'(cy_e);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yxc_reg <= yxc_next;
            yzs_reg <= yzs_next;
            yxs_reg <= yxs_next;
            yzc_reg <= yzc_next;
            ty2_reg <= ty_reg;
        end
    end

    // stage 3: yaw sums
    logic signed [W-1:0] x1_next, z1_next;
    logic signed [W-1:0] x1_reg, z1_reg, ty3_reg;

    always_comb
    begin
        x1_next = sat_rot(SW'(yxc_reg) + SW'(yzs_reg));
        z1_next = sat_rot(SW'(yxs_reg) + SW'(yzc_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x1_next;
            z1_reg  <= z1_next;
            ty3_reg <= ty2_reg;
        end
    end

    // stage 4: pitch products
    logic signed [PW-1:0] pyc_next, pzs_next, pys_next, pzc_next;
    logic signed [PW-1:0] pyc_reg, pzs_reg, pys_reg, pzc_reg;
    logic signed [W-1:0]  x1_4_reg;

    always_comb
    begin
        pyc_next = PW'(ty3_reg) * PW'(cp_e);
        pzs_next = PW'(z1_reg) * PW'(nsp_e);
        pys_next = PW'(ty3_reg) * PW'(sp_e);
        pzc_next = PW'(z1_reg) * PW'(cp_e);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pyc_reg  <= pyc_next;
            pzs_reg  <= pzs_next;
            pys_reg  <= pys_next;
            pzc_reg  <= pzc_next;
            x1_4_reg <= x1_reg;
        end
    end

    // stage 5: pitch sums
    logic signed [W-1:0] y2_next, z2_next;
    logic signed [W-1:0] y2_reg, z2_reg, x1_5_reg;

    always_comb
    begin
        y2_next = sat_rot(SW'(pyc_reg) + SW'(pzs_reg));
        z2_next = sat_rot(SW'(pys_reg) + SW'(pzc_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y2_reg   <= y2_next;
            z2_reg   <= z2_next;
            x1_5_reg <= x1_4_reg;
        end
    end

    // stage 6: numerators and denominator
    logic [NUMW-1:0]     num_x_reg, num_y_reg;
    logic [DENW-1:0]     den_next, den_reg;
    logic                neg_x_reg, neg_y_reg;
    logic signed [W-1:0] depth6_reg;
    logic                behind6_reg;

    assign den_next = DENW'(tan_half_fov_reg) * DENW'(z2_reg[W-2:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_x_reg   <= scaled_mag(x1_5_reg);
            num_y_reg   <= scaled_mag(y2_reg);
            neg_x_reg   <= x1_5_reg[W-1];
            neg_y_reg   <= y2_reg[W-1];
            den_reg     <= den_next;
            depth6_reg  <= z2_reg;
            behind6_reg <= z2_reg[W-1] | ~|z2_reg;
        end
    end

    // divider stages
    logic [W-1:0] quot_x, quot_y;
    logic [W-1:0] dly_depth_reg  [W];
    logic         dly_behind_reg [W];

    cpp_div #(.W(W)) u_div_x (
        .clk  (clk),
        .en   (en),
        .num  (num_x_reg),
        .den  (den_reg),
        .neg  (neg_x_reg),
        .quot (quot_x)
    );

    cpp_div #(.W(W)) u_div_y (
        .clk  (clk),
        .en   (en),
        .num  (num_y_reg),
        .den  (den_reg),
        .neg  (neg_y_reg),
        .quot (quot_y)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_depth_reg[0]  <= depth6_reg;
            dly_behind_reg[0] <= behind6_reg;
            for (int i = 1; i < W; i++)
            begin
                dly_depth_reg[i]  <= dly_depth_reg[i-1];
                dly_behind_reg[i] <= dly_behind_reg[i-1];
            end
        end
    end

    // output register and skid
    logic             pipe_valid;
    logic [RES_W-1:0] pipe_res;
    logic             take;
    logic             out_valid_next, skid_valid_next;
    logic [RES_W-1:0] out_res_next, skid_res_next;
    logic [RES_W-1:0] out_res_reg, skid_res_reg;

    always_comb
    begin
        pipe_valid = dly_valid_reg[W-1];
        pipe_res   = {dly_behind_reg[W-1], dly_depth_reg[W-1],
                      dly_behind_reg[W-1] ? {W{1'b0}} : quot_y,
                      dly_behind_reg[W-1] ? {W{1'b0}} : quot_x};
        take            = out_valid_reg & m_axis_tready;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (pipe_valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_res_next   = pipe_res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_res_next   = pipe_res;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'(out_res_reg[3*W-1:0]);
    assign m_axis_tuser  = out_res_reg[3*W];

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg[3*W]) |-> (out_res_reg[2*W-1:0] == '0))
        else $error("behind-camera beat carries nonzero screen coordinates");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> s1_valid_reg)
        else $error("accepted beat did not enter the first stage");

    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_axis_tready) |=> (skid_valid_reg && $stable(skid_res_reg)))
        else $error("skid beat lost or changed during a stall");
`endif

endmodule
